### sv/psdt_pkg.sv
// shared types and constants for the producer sequence check table
package psdt_pkg;

	localparam int MAX_PRODUCERS = 16;
	localparam int KEY_W = 64;
	localparam int NUM_W = 63;

	typedef enum logic [2:0] {
		ST_ACCEPTED      = 3'd0,
		ST_DUPLICATE     = 3'd1,
		ST_STALE_EPOCH   = 3'd2,
		ST_BAD_EPOCH_SEQ = 3'd3,
		ST_GAP           = 3'd4,
		ST_TABLE_FULL    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE
	} fsm_t;

	// lookup result handed along the row of cells
	typedef struct packed {
		logic             found;
		logic [NUM_W-1:0] epoch;
		logic [NUM_W-1:0] last;
	} lk_t;

	// write-back command broadcast to every cell
	typedef struct packed {
		logic             upd;
		logic             alloc;
		logic [KEY_W-1:0] key;
		logic [NUM_W-1:0] epoch;
		logic [NUM_W-1:0] seq;
	} wr_t;

endpackage

### sv/psdt_cell.sv
// one table entry: key match, lookup hand-off to the neighbor and write-back
module psdt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [psdt_pkg::KEY_W-1:0] look_key,
	input  logic                      look_en,
	input  psdt_pkg::lk_t             lk_in,
	output psdt_pkg::lk_t             lk_out,
	input  logic                      prev_valid,
	output logic                      valid,
	input  psdt_pkg::wr_t             wr
);
	import psdt_pkg::*;

	logic             valid_q;
	logic             hit_q;
	logic [KEY_W-1:0] key_q;
	logic [NUM_W-1:0] epoch_q;
	logic [NUM_W-1:0] last_q;
	logic             hit;
	logic             take_alloc;

	assign hit = valid_q && (key_q == look_key);
	assign take_alloc = wr.alloc && prev_valid && !valid_q;

	always_comb begin
		lk_out.found = lk_in.found | hit;
		lk_out.epoch = lk_in.epoch | (hit ? epoch_q : '0);
		lk_out.last  = lk_in.last | (hit ? last_q : '0);
	end

	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (look_en) begin
				hit_q <= hit;
			end
			if (take_alloc) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_alloc) begin
			key_q <= wr.key;
		end
		if (take_alloc || (wr.upd && hit_q)) begin
			epoch_q <= wr.epoch;
			last_q  <= wr.seq;
		end
	end

endmodule

### sv/producer_sequence_dedup_table_top.sv
// producer sequence check table: request capture, row of entry cells, classify and result register
// the request, the lookup result and the classified result are registered in turn
// one request in flight: the next is taken once capture, lookup, classify and write are done
// a new request is taken while the previous result still waits in the output register
// reset: all entries invalid, no result pending; entries fill lowest first and are never freed
// key, epoch and sequence storage is not reset and is read only after its entry is written
module producer_sequence_dedup_table_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [psdt_pkg::KEY_W-1:0]  producer_key,
	input  logic [psdt_pkg::NUM_W-1:0]  epoch,
	input  logic [psdt_pkg::NUM_W-1:0]  seq,
	input  logic                        commit,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output psdt_pkg::status_t           status,
	output logic [psdt_pkg::NUM_W-1:0]  exp_seq,
	output logic [psdt_pkg::NUM_W-1:0]  rcv_seq,
	output logic [psdt_pkg::NUM_W-1:0]  cur_epoch,
	output logic [psdt_pkg::NUM_W-1:0]  stored_seq
);
	import psdt_pkg::*;

	fsm_t             state_q, state_d;
	logic [KEY_W-1:0] key_q;
	logic [NUM_W-1:0] epoch_q;
	logic [NUM_W-1:0] seq_q;
	logic             commit_q;
	lk_t              lk_q;
	logic             rsp_valid_q;
	status_t          status_q;
	logic [NUM_W-1:0] exp_q, rcv_q, cur_q, last_q;

	lk_t              chain [MAX_PRODUCERS+1];
	logic             vchain [MAX_PRODUCERS+1];
	wr_t              wr;

	logic             req_fire;
	logic             out_free;
	logic             decide_fire;
	logic             full;
	logic [NUM_W-1:0] sl_inc;
	status_t          st_d;
	logic [NUM_W-1:0] exp_d, rcv_d, cur_d, last_d;
	logic             ok_commit;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign decide_fire = (state_q == S_DECIDE) && out_free;

	assign chain[0] = '0;
	assign vchain[0] = 1'b1;
	assign full = vchain[MAX_PRODUCERS];

	for (genvar i = 0; i < MAX_PRODUCERS; i++) begin : g_cell
		psdt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.look_key   (key_q),
			.look_en    (state_q == S_LOOK),
			.lk_in      (chain[i]),
			.lk_out     (chain[i+1]),
			.prev_valid (vchain[i]),
			.valid      (vchain[i+1]),
			.wr         (wr)
		);
	end

	// classify
	assign sl_inc = lk_q.last + {{(NUM_W-1){1'b0}}, 1'b1};

	always_comb begin
		st_d   = ST_ACCEPTED;
		exp_d  = '0;
		rcv_d  = '0;
		cur_d  = '0;
		last_d = '0;
		if (!lk_q.found) begin
			if (seq_q != '0) begin
				st_d  = ST_GAP;
				rcv_d = seq_q;
			end
		end else if (epoch_q < lk_q.epoch) begin
			st_d  = ST_STALE_EPOCH;
			cur_d = lk_q.epoch;
		end else if (epoch_q > lk_q.epoch) begin
			if (seq_q != '0) begin
				st_d = ST_BAD_EPOCH_SEQ;
			end
		end else if (seq_q <= lk_q.last) begin
			st_d   = ST_DUPLICATE;
			last_d = lk_q.last;
		end else if (seq_q != sl_inc) begin
			st_d  = ST_GAP;
			exp_d = sl_inc;
			rcv_d = seq_q;
		end
		ok_commit = (st_d == ST_ACCEPTED) && commit_q;
		if (ok_commit && !lk_q.found && full) begin
			st_d = ST_TABLE_FULL;
		end
	end

	always_comb begin
		wr.upd   = decide_fire && ok_commit && lk_q.found;
		wr.alloc = decide_fire && ok_commit && !lk_q.found && !full;
		wr.key   = key_q;
		wr.epoch = epoch_q;
		wr.seq   = seq_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (decide_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q    <= producer_key;
			epoch_q  <= epoch;
			seq_q    <= seq;
			commit_q <= commit;
		end
		if (state_q == S_LOOK) begin
			lk_q <= chain[MAX_PRODUCERS];
		end
		if (decide_fire) begin
			status_q <= st_d;
			exp_q    <= exp_d;
			rcv_q    <= rcv_d;
			cur_q    <= cur_d;
			last_q   <= last_d;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign exp_seq    = exp_q;
	assign rcv_seq    = rcv_q;
	assign cur_epoch  = cur_q;
	assign stored_seq = last_q;

endmodule

### sv/psdt_checker.sv
// port-level checks for the producer sequence check table
module psdt_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  psdt_pkg::status_t          status,
	input  logic [psdt_pkg::NUM_W-1:0] exp_seq,
	input  logic [psdt_pkg::NUM_W-1:0] rcv_seq,
	input  logic [psdt_pkg::NUM_W-1:0] cur_epoch,
	input  logic [psdt_pkg::NUM_W-1:0] stored_seq
);
	import psdt_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(stored_seq))
		else $error("stalled result beat changed");

	// one request in flight: busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// gap detail only on gap status
	a_gap_detail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_GAP |-> exp_seq == '0 && rcv_seq == '0)
		else $error("gap detail on non-gap status");

	// epoch and last detail only on their status
	a_other_detail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_STALE_EPOCH || cur_epoch == '0)
			&& (status == ST_DUPLICATE || stored_seq == '0))
		else $error("detail field set on wrong status");

endmodule

bind producer_sequence_dedup_table_top psdt_checker u_psdt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.status     (status),
	.exp_seq    (exp_seq),
	.rcv_seq    (rcv_seq),
	.cur_epoch  (cur_epoch),
	.stored_seq (stored_seq)
);

### test/tb_producer_sequence_dedup_table_top.sv
// testbench for the producer sequence check table: directed and random requests checked against a predicted table
module tb_producer_sequence_dedup_table_top;
	import psdt_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [NUM_W-1:0] NUM_MAX = '1;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	typedef struct packed {
		status_t          status;
		logic [NUM_W-1:0] exp_seq;
		logic [NUM_W-1:0] rcv_seq;
		logic [NUM_W-1:0] cur_epoch;
		logic [NUM_W-1:0] stored_seq;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [KEY_W-1:0] producer_key;
	logic [NUM_W-1:0] epoch;
	logic [NUM_W-1:0] seq;
	logic commit;
	logic rsp_valid;
	logic rsp_stall;
	status_t status;
	logic [NUM_W-1:0] exp_seq;
	logic [NUM_W-1:0] rcv_seq;
	logic [NUM_W-1:0] cur_epoch;
	logic [NUM_W-1:0] stored_seq;

	// predicted contents of the producer table
	logic [MAX_PRODUCERS-1:0] entry_used;
	logic [KEY_W-1:0] entry_key_copy [MAX_PRODUCERS];
	logic [NUM_W-1:0] entry_epoch_copy [MAX_PRODUCERS];
	logic [NUM_W-1:0] entry_last_copy [MAX_PRODUCERS];

	logic [KEY_W-1:0] producer_pool [MAX_PRODUCERS];
	verdict_t pending_verdicts [$];
	int error_count;
	int cycle_count;
	int send_idle_pct;
	int stall_pct;

	producer_sequence_dedup_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.producer_key(producer_key),
		.epoch(epoch),
		.seq(seq),
		.commit(commit),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.exp_seq(exp_seq),
		.rcv_seq(rcv_seq),
		.cur_epoch(cur_epoch),
		.stored_seq(stored_seq)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [NUM_W-1:0] rand63();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[NUM_W-1:0];
	endfunction

	function automatic int find_entry(input logic [KEY_W-1:0] key);
		for (int i = 0; i < MAX_PRODUCERS; i++) begin
			if (entry_used[i] && entry_key_copy[i] == key) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic bit is_pool_key(input logic [KEY_W-1:0] key, input int count);
		for (int i = 0; i < count; i++) begin
			if (producer_pool[i] == key) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] key;
		do key = {$urandom, $urandom}; while (is_pool_key(key, MAX_PRODUCERS));
		return key;
	endfunction

	// classifies one accepted request and applies its write-back to the table copy
	function automatic verdict_t classify_request(input logic [KEY_W-1:0] key,
			input logic [NUM_W-1:0] ep, input logic [NUM_W-1:0] sq, input logic cm);
		verdict_t v;
		int slot;
		logic [NUM_W-1:0] next_seq;
		v = '0;
		v.status = ST_ACCEPTED;
		slot = find_entry(key);
		if (slot < 0) begin
			if (sq != 0) begin
				v.status = ST_GAP;
				v.rcv_seq = sq;
			end
		end else if (ep < entry_epoch_copy[slot]) begin
			v.status = ST_STALE_EPOCH;
			v.cur_epoch = entry_epoch_copy[slot];
		end else if (ep > entry_epoch_copy[slot]) begin
			if (sq != 0) begin
				v.status = ST_BAD_EPOCH_SEQ;
			end
		end else if (sq <= entry_last_copy[slot]) begin
			v.status = ST_DUPLICATE;
			v.stored_seq = entry_last_copy[slot];
		end else begin
			next_seq = entry_last_copy[slot] + 1'b1;
			if (sq != next_seq) begin
				v.status = ST_GAP;
				v.exp_seq = next_seq;
				v.rcv_seq = sq;
			end
		end
		if (v.status == ST_ACCEPTED && cm) begin
			if (slot < 0) begin
				for (int i = 0; i < MAX_PRODUCERS; i++) begin
					if (slot < 0 && !entry_used[i]) begin
						slot = i;
					end
				end
				if (slot < 0) begin
					v.status = ST_TABLE_FULL;
				end else begin
					entry_used[slot] = 1'b1;
					entry_key_copy[slot] = key;
				end
			end
			if (slot >= 0) begin
				entry_epoch_copy[slot] = ep;
				entry_last_copy[slot] = sq;
			end
		end
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
	endtask

	task automatic send_request(input logic [KEY_W-1:0] key, input logic [NUM_W-1:0] ep,
			input logic [NUM_W-1:0] sq, input logic cm);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		producer_key <= key;
		epoch <= ep;
		seq <= sq;
		commit <= cm;
		do @(posedge clk); while (req_stall);
		pending_verdicts.push_back(classify_request(key, ep, sq, cm));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// result side: check at the rising edge, change stall at the falling edge
	initial begin
		verdict_t want;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch("result with nothing pending, status", status, 0);
				end else begin
					want = pending_verdicts.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (exp_seq !== want.exp_seq)
						report_mismatch("exp_seq", exp_seq, want.exp_seq);
					if (rcv_seq !== want.rcv_seq)
						report_mismatch("rcv_seq", rcv_seq, want.rcv_seq);
					if (cur_epoch !== want.cur_epoch)
						report_mismatch("cur_epoch", cur_epoch, want.cur_epoch);
					if (stored_seq !== want.stored_seq)
						report_mismatch("stored_seq", stored_seq, want.stored_seq);
				end
			end
			@(negedge clk);
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic test_directed_cases();
		send_request(64'd0, 63'd0, 63'd5, 1'b1);
		send_request(64'd0, 63'd0, NUM_MAX, 1'b1);
		send_request(64'd0, 63'd0, 63'd0, 1'b0);
		send_request(64'd0, 63'd0, 63'd1, 1'b1);
		send_request(64'd0, 63'd0, 63'd0, 1'b1);
		send_request(64'd0, 63'd0, 63'd0, 1'b1);
		send_request(64'd0, 63'd0, 63'd1, 1'b0);
		send_request(64'd0, 63'd0, 63'd1, 1'b1);
		send_request(64'd0, 63'd0, 63'd3, 1'b1);
		send_request(64'd0, 63'd0, NUM_MAX, 1'b1);
		send_request(KEY_MAX, NUM_MAX, 63'd0, 1'b1);
		send_request(KEY_MAX, NUM_MAX - 1'b1, 63'd0, 1'b1);
		send_request(KEY_MAX, 63'd0, 63'd7, 1'b1);
		send_request(KEY_MAX, NUM_MAX, 63'd1, 1'b1);
		send_request(64'd0, 63'd5, 63'd4, 1'b1);
		send_request(64'd0, 63'd5, NUM_MAX, 1'b1);
		send_request(64'd0, 63'd5, 63'd0, 1'b0);
		send_request(64'd0, 63'd5, 63'd0, 1'b1);
		send_request(64'd0, 63'd4, 63'd0, 1'b1);
		send_request(64'd0, 63'd5, 63'd1, 1'b1);
		send_request(64'd0, 63'd5, 63'd0, 1'b1);
	endtask

	task automatic test_table_full();
		for (int i = 0; i < MAX_PRODUCERS; i++) begin
			if (find_entry(producer_pool[i]) < 0) begin
				send_request(producer_pool[i], 63'($urandom_range(15)), 63'd0, 1'b1);
			end
		end
		send_request(fresh_key(), 63'd0, 63'd0, 1'b1);
		send_request(fresh_key(), NUM_MAX, 63'd0, 1'b1);
		send_request(fresh_key(), rand63(), 63'd0, 1'b0);
		send_request(fresh_key(), rand63(), 63'd9, 1'b1);
		wait_for_results();
	endtask

	task automatic send_random_request();
		logic [KEY_W-1:0] key;
		logic [NUM_W-1:0] ep;
		logic [NUM_W-1:0] sq;
		logic [NUM_W-1:0] cur_ep;
		logic [NUM_W-1:0] cur_last;
		logic cm;
		int slot;
		int pick;
		cm = ($urandom_range(99) < 85);
		ep = rand63();
		sq = rand63();
		if ($urandom_range(99) < 88) begin
			key = producer_pool[$urandom_range(MAX_PRODUCERS - 1)];
			slot = find_entry(key);
			pick = $urandom_range(99);
			if (slot < 0) begin
				if ($urandom_range(9) < 7)
					ep = 63'($urandom_range(15));
				if (pick < 75)
					sq = 63'd0;
			end else begin
				cur_ep = entry_epoch_copy[slot];
				cur_last = entry_last_copy[slot];
				ep = cur_ep;
				if (pick < 55) begin
					sq = cur_last + 1'b1;
				end else if (pick < 65) begin
					sq = (cur_last == NUM_MAX) ? rand63() : rand63() % (cur_last + 1'b1);
				end else if (pick < 73) begin
					if (pick < 70)
						sq = cur_last + 2 + $urandom_range(3);
				end else if (pick < 81) begin
					if (cur_ep != 0)
						ep = rand63() % cur_ep;
					if ($urandom_range(1))
						sq = cur_last + 1'b1;
				end else if (pick < 93) begin
					if (cur_ep == NUM_MAX)
						ep = cur_ep;
					else if (cur_ep < NUM_MAX - 8 && $urandom_range(9) != 0)
						ep = cur_ep + 1 + $urandom_range(7);
					else
						ep = cur_ep + 1'b1 + rand63() % (NUM_MAX - cur_ep);
					if (pick < 89)
						sq = 63'd0;
				end
			end
		end else begin
			// unknown producer: may only allocate once the table is full
			key = fresh_key();
			if ($urandom_range(1))
				sq = 63'd0;
			if (!(&entry_used) && sq == 0)
				cm = 1'b0;
		end
		send_request(key, ep, sq, cm);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_chance, input int count);
		send_idle_pct = idle_pct;
		stall_pct = stall_chance;
		for (int i = 0; i < count; i++) begin
			send_random_request();
		end
		wait_for_results();
	endtask

	initial begin
		logic [KEY_W-1:0] key;
		arst_n = 1'b0;
		req_valid = 1'b0;
		producer_key = '0;
		epoch = '0;
		seq = '0;
		commit = 1'b0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		entry_used = '0;
		producer_pool[0] = '0;
		producer_pool[1] = KEY_MAX;
		for (int i = 2; i < MAX_PRODUCERS; i++) begin
			do key = {$urandom, $urandom}; while (is_pool_key(key, i));
			producer_pool[i] = key;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		wait_for_results();
		test_random_traffic(0, 0, 425);
		test_table_full();
		test_random_traffic(71, 0, 425);
		test_random_traffic(0, 71, 425);
		test_random_traffic(21, 21, 425);

		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### files.f
sv/psdt_pkg.sv
sv/psdt_cell.sv
sv/producer_sequence_dedup_table_top.sv
sv/psdt_checker.sv
test/tb_producer_sequence_dedup_table_top.sv
